@@ rtl/rac_pkg.sv @@
// Shared types and constants for the rational add and compare block.
package rac_pkg;

  localparam int SUM_NUM_W = 32;
  localparam int SUM_DEN_W = 31;
  localparam int OUT_TW    = 64;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_EQ   = 2'd1,
    OP_GT   = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_RSTART = 5'b00100,
    ST_RED    = 5'b01000,
    ST_DONE   = 5'b10000
  } rac_state_t;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_GCD  = 4'b0010,
    R_DIV  = 4'b0100,
    R_FIN  = 4'b1000
  } red_state_t;

endpackage

@@ rtl/rac_reduce.sv @@
// Iterative fraction reducer: binary gcd followed by two restoring divisions.
module rac_reduce #(
  parameter int NW = 32,
  localparam int CW = $clog2(NW)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] n_in,
  input  logic        [NW-1:0] d_in,
  output logic                 done,
  output logic signed [NW-1:0] n_out,
  output logic        [NW-1:0] d_out
);
  import rac_pkg::*;

  red_state_t         state_r, state_nxt;
  logic signed [NW-1:0] n_r, n_nxt;
  logic [NW-1:0]      d_r, d_nxt;
  logic [NW-1:0]      u_r, u_nxt;
  logic [NW-1:0]      v_r, v_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               sel_r, sel_nxt;

  logic [NW-1:0]      div_x;
  logic [NW:0]        div_t;
  logic               div_ge;
  logic [NW:0]        div_rem;
  logic [NW-1:0]      div_q;

  assign div_x   = sel_r ? d_r : $unsigned(n_r);
  assign div_t   = {v_r, div_x[NW-1]};
  assign div_ge  = div_t >= {1'b0, u_r};
  assign div_rem = div_ge ? (div_t - {1'b0, u_r}) : div_t;
  assign div_q   = {div_x[NW-2:0], div_ge};

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          n_nxt = n_in;
          d_nxt = d_in;
          u_nxt = $unsigned(n_in);
          v_nxt = d_in;
          k_nxt = '0;
          if (!n_in[NW-1] && ($unsigned(n_in) > NW'(1)) && (d_in > NW'(1))) begin
            state_nxt = R_GCD;
          end else begin
            state_nxt = R_FIN;
          end
        end
      end
      R_GCD: begin
        if (u_r == v_r) begin
          if ((u_r == NW'(1)) && (k_r == '0)) begin
            state_nxt = R_FIN;
          end else begin
            u_nxt     = u_r << k_r;
            v_nxt     = '0;
            cnt_nxt   = '0;
            sel_nxt   = 1'b0;
            state_nxt = R_DIV;
          end
        end else begin
          priority if (!u_r[0] && !v_r[0]) begin
            u_nxt = u_r >> 1;
            v_nxt = v_r >> 1;
            k_nxt = k_r + CW'(1);
          end else if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else if (u_r > v_r) begin
            u_nxt = (u_r - v_r) >> 1;
          end else begin
            v_nxt = (v_r - u_r) >> 1;
          end
        end
      end
      R_DIV: begin
        v_nxt   = div_rem[NW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (sel_r) begin
          d_nxt = div_q;
        end else begin
          n_nxt = $signed(div_q);
        end
        if (cnt_r == CW'(NW - 1)) begin
          cnt_nxt = '0;
          v_nxt   = '0;
          if (sel_r) begin
            state_nxt = R_FIN;
          end else begin
            sel_nxt = 1'b1;
          end
        end
      end
      R_FIN: begin
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    sel_r <= sel_nxt;
  end

  assign done  = (state_r == R_FIN);
  assign n_out = n_r;
  assign d_out = (n_r == '0) ? '0 : d_r;

endmodule

@@ rtl/rational_add_compare.sv @@
// Rational add, equal and greater unit on two fractions, one transaction at a time.
// Path from input transaction to result valid: add with a zero denominator and the
// unused opcode go straight to the output stage, greater takes the multiply steps, add
// takes the multiply steps and then rac_reduce, and equal runs rac_reduce once per fraction.
// Throughput: one transaction in flight; in_tready returns once the result is registered.
// Reset (rst_n low, synchronous): sequencer idle, output register empty.
module rational_add_compare #(
  parameter int IN_WIDTH = 16,
  localparam int IN_TW = ((4 * IN_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TW-1:0]           in_tdata,   // opcode, a_num, a_den, b_num, b_den
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rac_pkg::OUT_TW-1:0] out_tdata   // sum_num, sum_den, flag
);
  import rac_pkg::*;

  localparam int W  = IN_WIDTH;
  localparam int NW = 2 * IN_WIDTH;
  localparam int EW = (NW > SUM_NUM_W) ? NW : SUM_NUM_W;

  rac_state_t           state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic signed [W-1:0]  an_r, an_nxt;
  logic [W-2:0]         ad_r, ad_nxt;
  logic signed [W-1:0]  bn_r, bn_nxt;
  logic [W-2:0]         bd_r, bd_nxt;
  logic [1:0]           mcnt_r, mcnt_nxt;
  logic signed [NW-1:0] p0_r, p0_nxt;
  logic signed [NW-1:0] p1_r, p1_nxt;
  logic signed [NW-1:0] n_r, n_nxt;
  logic [NW-1:0]        d_r, d_nxt;
  logic signed [NW-1:0] xn_r, xn_nxt;
  logic [NW-1:0]        xd_r, xd_nxt;
  logic                 pass_r, pass_nxt;
  logic                 flag_r, flag_nxt;
  logic                 out_valid_r;
  logic [SUM_NUM_W-1:0] out_num_r;
  logic [SUM_DEN_W-1:0] out_den_r;
  logic                 out_flag_r;

  logic                 in_acc;
  logic                 out_load;
  op_t                  in_op;
  logic signed [W-1:0]  in_a_num;
  logic [W-2:0]         in_a_den;
  logic signed [W-1:0]  in_b_num;
  logic [W-2:0]         in_b_den;
  logic signed [W-1:0]  ma;
  logic signed [W-1:0]  mb;
  logic signed [NW-1:0] prod;
  logic signed [NW-1:0] gt_x;
  logic signed [NW-1:0] gt_y;
  logic signed [EW-1:0] num_ext;
  logic [EW-1:0]        den_ext;

  logic                 red_start;
  logic                 red_done;
  logic signed [NW-1:0] red_n;
  logic [NW-1:0]        red_d;

  assign in_op    = op_t'(in_tdata[1:0]);
  assign in_a_num = in_tdata[2 +: W];
  assign in_a_den = in_tdata[2 + W +: W - 1];
  assign in_b_num = in_tdata[1 + 2 * W +: W];
  assign in_b_den = in_tdata[1 + 3 * W +: W - 1];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign red_start = (state_r == ST_RSTART);

  always_comb begin
    unique case (mcnt_r)
      2'd0: begin
        ma = an_r;
        mb = $signed({1'b0, bd_r});
      end
      2'd1: begin
        ma = bn_r;
        mb = $signed({1'b0, ad_r});
      end
      default: begin
        ma = $signed({1'b0, ad_r});
        mb = $signed({1'b0, bd_r});
      end
    endcase
  end

  assign prod = ma * mb;

  assign gt_x = (ad_r == '0) ? '0 : ((bd_r == '0) ? NW'(an_r) : p0_r);
  assign gt_y = (bd_r == '0) ? '0 : ((ad_r == '0) ? NW'(bn_r) : p1_r);

  rac_reduce #(
    .NW(NW)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .n_in  (n_r),
    .d_in  (d_r),
    .done  (red_done),
    .n_out (red_n),
    .d_out (red_d)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    an_nxt    = an_r;
    ad_nxt    = ad_r;
    bn_nxt    = bn_r;
    bd_nxt    = bd_r;
    mcnt_nxt  = mcnt_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    xn_nxt    = xn_r;
    xd_nxt    = xd_r;
    pass_nxt  = pass_r;
    flag_nxt  = flag_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_op;
          an_nxt   = in_a_num;
          ad_nxt   = in_a_den;
          bn_nxt   = in_b_num;
          bd_nxt   = in_b_den;
          mcnt_nxt = '0;
          pass_nxt = 1'b0;
          flag_nxt = 1'b0;
          n_nxt    = '0;
          d_nxt    = '0;
          unique case (in_op)
            OP_ADD: begin
              if (in_a_den == '0) begin
                n_nxt     = NW'(in_b_num);
                d_nxt     = NW'(in_b_den);
                state_nxt = ST_DONE;
              end else if (in_b_den == '0) begin
                n_nxt     = NW'(in_a_num);
                d_nxt     = NW'(in_a_den);
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_MUL;
              end
            end
            OP_EQ: begin
              n_nxt     = NW'(in_a_num);
              d_nxt     = NW'(in_a_den);
              state_nxt = ST_RSTART;
            end
            OP_GT: begin
              state_nxt = ST_MUL;
            end
            OP_NONE: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_MUL: begin
        mcnt_nxt = mcnt_r + 2'd1;
        unique case (mcnt_r)
          2'd0: p0_nxt = prod;
          2'd1: p1_nxt = prod;
          2'd2: d_nxt  = $unsigned(prod);
          2'd3: begin
            if (op_r == OP_GT) begin
              flag_nxt  = (gt_x > gt_y);
              n_nxt     = '0;
              d_nxt     = '0;
              state_nxt = ST_DONE;
            end else begin
              n_nxt     = p0_r + p1_r;
              state_nxt = ST_RSTART;
            end
          end
        endcase
      end
      ST_RSTART: begin
        state_nxt = ST_RED;
      end
      ST_RED: begin
        if (red_done) begin
          if (op_r == OP_ADD) begin
            n_nxt     = red_n;
            d_nxt     = red_d;
            state_nxt = ST_DONE;
          end else if (!pass_r) begin
            xn_nxt    = red_n;
            xd_nxt    = red_d;
            n_nxt     = NW'(bn_r);
            d_nxt     = NW'(bd_r);
            pass_nxt  = 1'b1;
            state_nxt = ST_RSTART;
          end else begin
            flag_nxt  = (xn_r == red_n) && (xd_r == red_d);
            n_nxt     = '0;
            d_nxt     = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign num_ext = EW'(n_r);
  assign den_ext = EW'(d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    an_r   <= an_nxt;
    ad_r   <= ad_nxt;
    bn_r   <= bn_nxt;
    bd_r   <= bd_nxt;
    mcnt_r <= mcnt_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    xn_r   <= xn_nxt;
    xd_r   <= xd_nxt;
    pass_r <= pass_nxt;
    flag_r <= flag_nxt;
    if (out_load) begin
      out_num_r  <= num_ext[SUM_NUM_W-1:0];
      out_den_r  <= den_ext[SUM_DEN_W-1:0];
      out_flag_r <= flag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_flag_r, out_den_r, out_num_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a transaction");

  a_reduce_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> (state_r == ST_RED))
    else $error("reducer finished outside the wait state");

  a_compare_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (op_r != OP_ADD) |=> (out_tdata[SUM_NUM_W+SUM_DEN_W-1:0] == '0))
    else $error("compare result carries a nonzero sum");

  a_add_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (op_r == OP_ADD) |=> !out_tdata[OUT_TW-1])
    else $error("add result carries a set flag");

endmodule
